>>> hdl/rttpb_pkg.sv
`default_nettype none
package rttpb_pkg;

    // Estimator value width and saturation point
    localparam int EST_W   = 15;
    localparam int CFG_W   = 16;
    localparam int SHIFT_W = 4;
    localparam logic [EST_W-1:0] EST_SAT = {EST_W{1'b1}};

    // Cap on the persist multiplier exponent
    localparam int BACKOFF_CAP_EXP = 6;
    localparam logic [SHIFT_W-1:0] BACKOFF_CAP = SHIFT_W'(BACKOFF_CAP_EXP);

    // Width of the raw persist product and of the clamp compare
    localparam int PERSIST_RAW_W = EST_W + BACKOFF_CAP_EXP;
    localparam int CLAMP_W = (PERSIST_RAW_W > CFG_W) ? PERSIST_RAW_W : CFG_W;

    // Signed width for the smoothing arithmetic
    localparam int SUM_W = EST_W + 3;

    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 72;
    localparam int M_FIELDS_W = 2 * EST_W + 2 * CFG_W + SHIFT_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RTO_MIN     = 3'd0,
        REG_RTO_MAX     = 3'd1,
        REG_PERSIST_MIN = 3'd2,
        REG_PERSIST_MAX = 3'd3,
        REG_MAX_BACKOFF = 3'd4
    } cfg_reg_t;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_PERSIST = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0]   rto_min;
        logic [CFG_W-1:0]   rto_max;
        logic [CFG_W-1:0]   persist_min;
        logic [CFG_W-1:0]   persist_max;
        logic [SHIFT_W-1:0] max_backoff_shift;
    } cfg_t;

    typedef struct packed {
        logic [EST_W-1:0]   srtt;
        logic [EST_W-1:0]   dev;
        logic [SHIFT_W-1:0] shift;
    } est_state_t;

    // Base timeout: ((srtt >> 2) + rttvar) >> 1
    function automatic logic [EST_W-1:0] base_timeout(input logic [EST_W-1:0] srtt,
                                                      input logic [EST_W-1:0] dev);
        logic [EST_W:0] sum;
        sum = (EST_W+1)'(srtt[EST_W-1:2]) + (EST_W+1)'(dev);
        return sum[EST_W:1];
    endfunction

    // Low bound wins when bounds cross
    function automatic logic [CFG_W-1:0] range_clamp(input logic [CLAMP_W-1:0] v,
                                                     input logic [CFG_W-1:0] lo,
                                                     input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v < CLAMP_W'(lo)) begin
            r = lo;
        end else if (v > CLAMP_W'(hi)) begin
            r = hi;
        end else begin
            r = v[CFG_W-1:0];
        end
        return r;
    endfunction

    // Keep estimator values within 1 .. EST_SAT
    function automatic logic [EST_W-1:0] fit_est(input logic signed [SUM_W-1:0] v);
        logic [EST_W-1:0] r;
        if (v <= 0) begin
            r = EST_W'(1);
        end else if (v > $signed(SUM_W'(EST_SAT))) begin
            r = EST_SAT;
        end else begin
            r = v[EST_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/rttpb_update.sv
`default_nettype none
module rttpb_update import rttpb_pkg::*; (
    input  logic                     func,
    input  logic [EST_W-1:0]         rtt_ticks,
    input  logic [SHIFT_W-1:0]       max_backoff_shift,
    input  est_state_t               cur,
    output est_state_t               nxt,
    output logic [CLAMP_W-1:0]       persist_raw
);

    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] mag;
    logic signed [SUM_W-1:0] srtt_sum;
    logic signed [SUM_W-1:0] dev_sum;
    logic [EST_W-1:0]        seed_srtt;
    logic [EST_W-1:0]        seed_dev;
    logic [EST_W-1:0]        t_old;
    logic [SHIFT_W-1:0]      mult_exp;

    // Smoothing of a later sample
    assign delta    = $signed(SUM_W'(rtt_ticks)) - $signed(SUM_W'(1))
                    - $signed(SUM_W'(cur.srtt[EST_W-1:3]));
    assign srtt_sum = $signed(SUM_W'(cur.srtt)) + delta;
    assign mag      = delta[SUM_W-1] ? -delta : delta;
    assign dev_sum  = $signed(SUM_W'(cur.dev)) + mag
                    - $signed(SUM_W'(cur.dev[EST_W-1:2]));

    // First sample seeds, saturating
    assign seed_srtt = (rtt_ticks[EST_W-1:EST_W-3] != 3'd0) ? EST_SAT
                                                              : {rtt_ticks[EST_W-4:0], 3'b000};
    assign seed_dev  = rtt_ticks[EST_W-1] ? EST_SAT : {rtt_ticks[EST_W-2:0], 1'b0};

    // Persist product from the state before the beat
    assign t_old       = base_timeout(cur.srtt, cur.dev);
    assign mult_exp    = (cur.shift < BACKOFF_CAP) ? cur.shift : BACKOFF_CAP;
    assign persist_raw = CLAMP_W'(t_old) << mult_exp;

    always_comb begin
        nxt = cur;
        if (func == FUNC_MEASURE) begin
            if (cur.srtt != '0) begin
                nxt.srtt = fit_est(srtt_sum);
                nxt.dev  = fit_est(dev_sum);
            end else begin
                nxt.srtt = seed_srtt;
                nxt.dev  = seed_dev;
            end
            nxt.shift = '0;
        end else if (cur.shift < max_backoff_shift) begin
            nxt.shift = cur.shift + SHIFT_W'(1);
        end
    end

endmodule
`default_nettype wire

>>> hdl/rttpb_timeout.sv
`default_nettype none
module rttpb_timeout import rttpb_pkg::*; (
    input  logic               func,
    input  est_state_t         st,
    input  logic [CLAMP_W-1:0] persist_raw,
    input  cfg_t               cfg,
    output logic [CFG_W-1:0]   rto_ticks,
    output logic [CFG_W-1:0]   persist_ticks
);

    logic [EST_W-1:0] t_new;

    assign t_new     = base_timeout(st.srtt, st.dev);
    assign rto_ticks = range_clamp(CLAMP_W'(t_new), cfg.rto_min, cfg.rto_max);

    // Measurement beats report no persist timeout
    assign persist_ticks = (func == FUNC_PERSIST)
                         ? range_clamp(persist_raw, cfg.persist_min, cfg.persist_max)
                         : '0;

endmodule
`default_nettype wire

>>> hdl/rtt_estimator_persist_backoff.sv
// Pipeline: a beat accepted on s_tready passes the input register, the state update stage and
//   the result register before it shows on m_tvalid, absent backpressure.
// Throughput: one beat per cycle unless m_tready stalls it; est_reg alone closes the loop.
// Reset (aresetn low, synchronous): pipeline emptied, estimator state and backoff cleared,
//   configuration registers back to their defaults.
`default_nettype none
module rtt_estimator_persist_backoff import rttpb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,

    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [14:0] rtt_ticks, [15] zero
    input  logic                  s_tuser,   // [0] func

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [14:0] srtt_scaled, [29:15] rttvar_scaled,
                                             // [45:30] rto_ticks, [61:46] persist_ticks,
                                             // [65:62] backoff_level, [71:66] zero
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rto_min           <= CFG_W'(2);
            cfg_reg.rto_max           <= CFG_W'(128);
            cfg_reg.persist_min       <= CFG_W'(10);
            cfg_reg.persist_max       <= CFG_W'(120);
            cfg_reg.max_backoff_shift <= SHIFT_W'(12);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_RTO_MIN:     cfg_reg.rto_min           <= cfg_wdata;
                REG_RTO_MAX:     cfg_reg.rto_max           <= cfg_wdata;
                REG_PERSIST_MIN: cfg_reg.persist_min       <= cfg_wdata;
                REG_PERSIST_MAX: cfg_reg.persist_max       <= cfg_wdata;
                REG_MAX_BACKOFF: cfg_reg.max_backoff_shift <= cfg_wdata[SHIFT_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage advances when the one after it
    // is empty or draining, so a result waiting on m_tready stalls the
    // input only once all three stages hold a beat.
    // ------------------------------------------------------------------
    logic in_valid_reg,  in_valid_next;
    logic mid_valid_reg, mid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_ready, mid_ready, in_ready;
    logic in_take, mid_take, out_take;

    assign out_ready = !out_valid_reg || m_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg  || mid_ready;

    assign in_take  = s_tvalid      && in_ready;
    assign mid_take = in_valid_reg  && mid_ready;
    assign out_take = mid_valid_reg && out_ready;

    always_comb begin
        in_valid_next  = in_ready  ? s_tvalid      : in_valid_reg;
        mid_valid_next = mid_ready ? in_valid_reg  : mid_valid_reg;
        out_valid_next = out_ready ? mid_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold the beat's payload
    // ------------------------------------------------------------------
    logic             func_reg;
    logic [EST_W-1:0] rtt_reg;

    always_ff @(posedge aclk) begin
        if (in_take) begin
            func_reg <= s_tuser;
            rtt_reg  <= s_tdata[EST_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // State update stage: smooth or seed the estimate, advance or clear
    // the backoff shift, form the raw persist product.
    // ------------------------------------------------------------------
    est_state_t         est_reg;
    est_state_t         est_next;
    logic [CLAMP_W-1:0] persist_raw;

    rttpb_update u_update (
        .func              (func_reg),
        .rtt_ticks         (rtt_reg),
        .max_backoff_shift (cfg_reg.max_backoff_shift),
        .cur               (est_reg),
        .nxt               (est_next),
        .persist_raw       (persist_raw)
    );

    // Commit the state as the beat leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
        end else if (mid_take) begin
            est_reg <= est_next;
        end
    end

    est_state_t         mid_est_reg;
    logic               mid_func_reg;
    logic [CLAMP_W-1:0] mid_persist_reg;

    always_ff @(posedge aclk) begin
        if (mid_take) begin
            mid_est_reg     <= est_next;
            mid_func_reg    <= func_reg;
            mid_persist_reg <= persist_raw;
        end
    end

    // ------------------------------------------------------------------
    // Timeout stage: clamp retransmit and persist timeouts
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] rto_ticks;
    logic [CFG_W-1:0] persist_ticks;

    rttpb_timeout u_timeout (
        .func          (mid_func_reg),
        .st            (mid_est_reg),
        .persist_raw   (mid_persist_reg),
        .cfg           (cfg_reg),
        .rto_ticks     (rto_ticks),
        .persist_ticks (persist_ticks)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [M_FIELDS_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_data_reg <= {mid_est_reg.shift, persist_ticks, rto_ticks,
                             mid_est_reg.dev, mid_est_reg.srtt};
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

endmodule
`default_nettype wire

>>> hdl/rttpb_checker.sv
`default_nettype none
module rttpb_checker import rttpb_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Fill bits above the packed fields stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0))
        else $error("nonzero fill bits in result");

    // Once an estimate exists the deviation is at least one
    a_dev_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[EST_W-1:0] != '0)) |-> (m_tdata[2*EST_W-1:EST_W] != '0))
        else $error("deviation zero with a live estimate");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind rtt_estimator_persist_backoff rttpb_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> verif/tb.sv
module tb;
    import rttpb_pkg::*;

    // Register index that maps to no register; writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int N_DIRECTED  = 24;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 200;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    // One result beat, fields named as on m_tdata
    typedef struct packed {
        logic [EST_W-1:0]   srtt;
        logic [EST_W-1:0]   rttvar;
        logic [CFG_W-1:0]   rto;
        logic [CFG_W-1:0]   persist;
        logic [SHIFT_W-1:0] backoff;
    } timer_result_t;

    // Directed stimulus row; typed rows carry a hand-derived expectation
    typedef struct packed {
        logic          fn;
        logic [14:0]   rtt;
        logic          typed;
        timer_result_t want;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Predictor copy of the configuration and estimator state
    cfg_t       timer_cfg;
    est_state_t est;

    timer_result_t pending_timers[$];
    int            timer_mismatches = 0;
    int            beats_out = 0;
    int            cycle_count = 0;

    // Idle rates in percent, and long-hold requests for the receiver
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;

    directed_row_t directed_rows [N_DIRECTED];

    rtt_estimator_persist_backoff dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [14:0] rtt_ticks, [15] zero
        .s_tuser   (s_tuser),    // [0] func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // [14:0] srtt, [29:15] rttvar, [45:30] rto,
                                 // [61:46] persist, [65:62] backoff, [71:66] zero
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Bound the run; a hang ends as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Estimator values stay within 1 .. saturation after smoothing
    function automatic logic [EST_W-1:0] pin_est(input int v);
        if (v <= 0) return EST_W'(1);
        if (v > int'(EST_SAT)) return EST_SAT;
        return EST_W'(v);
    endfunction

    // Low bound checked first, so crossed bounds resolve to the low one
    function automatic logic [CFG_W-1:0] bound_ticks(input int unsigned v,
                                                     input logic [CFG_W-1:0] lo,
                                                     input logic [CFG_W-1:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return CFG_W'(v);
    endfunction

    function automatic int unsigned timeout_base();
        return ((int'(est.srtt) >> 2) + int'(est.dev)) >> 1;
    endfunction

    // Advance the estimator by one item and return the result it reports
    function automatic timer_result_t predict_timers(input logic fn,
                                                     input logic [14:0] rtt);
        int            delta;
        int            mag;
        int            seed;
        int unsigned   cap_exp;
        timer_result_t r;
        r = '0;
        if (fn == FUNC_MEASURE) begin
            if (est.srtt != '0) begin
                // Smooth: both terms use the state before this sample
                delta = int'(rtt) - 1 - int'(est.srtt >> 3);
                mag = (delta < 0) ? -delta : delta;
                mag = mag - int'(est.dev >> 2);
                est.srtt = pin_est(int'(est.srtt) + delta);
                est.dev = pin_est(int'(est.dev) + mag);
            end else begin
                // First sample seeds both; a zero sample keeps the no-sample state
                seed = int'(rtt) * 8;
                est.srtt = (seed > int'(EST_SAT)) ? EST_SAT : EST_W'(seed);
                seed = int'(rtt) * 2;
                est.dev = (seed > int'(EST_SAT)) ? EST_SAT : EST_W'(seed);
            end
            est.shift = '0;
        end else begin
            cap_exp = (est.shift < BACKOFF_CAP) ? int'(est.shift) : BACKOFF_CAP_EXP;
            r.persist = bound_ticks(timeout_base() << cap_exp,
                                    timer_cfg.persist_min, timer_cfg.persist_max);
            if (est.shift < timer_cfg.max_backoff_shift) est.shift = est.shift + 1'b1;
        end
        r.srtt    = est.srtt;
        r.rttvar  = est.dev;
        r.rto     = bound_ticks(timeout_base(), timer_cfg.rto_min, timer_cfg.rto_max);
        r.backoff = est.shift;
        return r;
    endfunction

    // Offer one beat after a random idle gap; hold it until accepted, then
    // queue what it should produce. A typed row overrides the predicted value.
    task automatic send_item(input logic fn, input logic [14:0] rtt,
                             input logic typed, input timer_result_t want);
        timer_result_t r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, rtt};
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        r = predict_timers(fn, rtt);
        pending_timers.push_back(typed ? want : r);
    endtask

    // Drop valid and wait for every outstanding result, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_timers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all registers in order, then poke an unmapped index that must be ignored
    task automatic program_regs(input logic [CFG_W-1:0] lo_rto, input logic [CFG_W-1:0] hi_rto,
                                input logic [CFG_W-1:0] lo_per, input logic [CFG_W-1:0] hi_per,
                                input logic [CFG_W-1:0] shift_cap);
        logic [CFG_ADDR_W-1:0] regs [6];
        logic [CFG_W-1:0]      vals [6];
        regs = '{REG_RTO_MIN, REG_RTO_MAX, REG_PERSIST_MIN, REG_PERSIST_MAX,
                 REG_MAX_BACKOFF, REG_UNMAPPED};
        vals = '{lo_rto, hi_rto, lo_per, hi_per, shift_cap, CFG_W'($urandom)};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (regs[i])
                REG_RTO_MIN:     timer_cfg.rto_min = vals[i];
                REG_RTO_MAX:     timer_cfg.rto_max = vals[i];
                REG_PERSIST_MIN: timer_cfg.persist_min = vals[i];
                REG_PERSIST_MAX: timer_cfg.persist_max = vals[i];
                REG_MAX_BACKOFF: timer_cfg.max_backoff_shift = vals[i][SHIFT_W-1:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Pick a sample: mostly near the current estimate, some wide, a few extremes
    function automatic logic [14:0] pick_rtt();
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 32767);
            1:       v = $urandom_range(0, 1) ? 32767 : 0;
            2, 3:    v = $urandom_range(1000, 32767);
            4:       v = $urandom_range(1, 64);
            default: begin
                v = int'(est.srtt >> 3) + $urandom_range(0, 40) - 20;
                if (v < 0) v = 0;
                if (v > 32767) v = 32767;
            end
        endcase
        return 15'(v);
    endfunction

    // Receiver: random stalls at the current rate, plus long holds on request
    always @(posedge aclk) begin : rx_side
        int hold_left;
        int hold_taken;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req != hold_taken) begin
            m_tready <= 1'b0;
            hold_left = LONG_HOLD;
            hold_taken = hold_req;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        timer_result_t got;
        timer_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.srtt    = m_tdata[EST_W-1:0];
            got.rttvar  = m_tdata[2*EST_W-1:EST_W];
            got.rto     = m_tdata[2*EST_W+CFG_W-1:2*EST_W];
            got.persist = m_tdata[2*EST_W+2*CFG_W-1:2*EST_W+CFG_W];
            got.backoff = m_tdata[M_FIELDS_W-1:2*EST_W+2*CFG_W];
            beats_out = beats_out + 1;
            if (pending_timers.size() == 0) begin
                timer_mismatches = timer_mismatches + 1;
                if (timer_mismatches <= 10)
                    $display("result beat %0d arrived with nothing expected", beats_out);
            end else begin
                want = pending_timers.pop_front();
                if (got !== want) begin
                    timer_mismatches = timer_mismatches + 1;
                    if (timer_mismatches <= 10) begin
                        $display("result beat %0d (expected/got): srtt %0d/%0d rttvar %0d/%0d",
                                 beats_out, want.srtt, got.srtt, want.rttvar, got.rttvar);
                        $display("  rto %0d/%0d persist %0d/%0d backoff %0d/%0d",
                                 want.rto, got.rto, want.persist, got.persist,
                                 want.backoff, got.backoff);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int sent;
        int run_len;
        logic [14:0] junk_rtt;
        logic paused;

        // Predictor starts from the reset state
        timer_cfg.rto_min           = 16'd2;
        timer_cfg.rto_max           = 16'd128;
        timer_cfg.persist_min       = 16'd10;
        timer_cfg.persist_max       = 16'd120;
        timer_cfg.max_backoff_shift = 4'd12;
        est = '0;
        paused = 1'b0;

        // Directed rows at reset defaults. Expectations fields: srtt, rttvar,
        // rto, persist, backoff.
        directed_rows[0] = '{FUNC_PERSIST, 15'd0, 1'b1, '{15'd0, 15'd0, 16'd2, 16'd10, 4'd1}};
        // zero sample before any sample leaves the estimator empty
        directed_rows[1] = '{FUNC_MEASURE, 15'd0, 1'b1, '{15'd0, 15'd0, 16'd2, 16'd0, 4'd0}};
        // largest first sample saturates both values
        directed_rows[2] = '{FUNC_MEASURE, 15'd32767, 1'b1,
                             '{15'd32767, 15'd32767, 16'd128, 16'd0, 4'd0}};
        directed_rows[3] = '{FUNC_PERSIST, 15'd32767, 1'b1,
                             '{15'd32767, 15'd32767, 16'd128, 16'd120, 4'd1}};
        directed_rows[4] = '{FUNC_MEASURE, 15'd32767, 1'b1,
                             '{15'd32767, 15'd32767, 16'd128, 16'd0, 4'd0}};
        // pull the estimate down, then zero samples on a live estimate
        for (int i = 5; i < 9; i++)
            directed_rows[i] = '{FUNC_MEASURE, 15'd1, 1'b0, '0};
        for (int i = 9; i < 11; i++)
            directed_rows[i] = '{FUNC_MEASURE, 15'd0, 1'b0, '0};
        // climb the backoff to its limit and one step past it
        for (int i = 11; i < N_DIRECTED; i++)
            directed_rows[i] = '{FUNC_PERSIST, (i % 2) ? 15'h7fff : 15'h0000, 1'b0, '0};

        // Hold reset, then release it on a rising edge
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 10;
        rx_idle_pct = 49;
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].fn, directed_rows[i].rtt,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Idle profile: sender light / receiver heavy, then swapped, then none
            if (ph < 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 49;
            end else if (ph < 5) begin
                tx_idle_pct = 49;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // Reprogram only with the pipe empty
            if (ph > 0) drain_results();
            case (ph)
                1: program_regs(16'd1, 16'd65535, 16'd1, 16'd65535, 16'd15);
                // crossed bounds on both ranges, backoff frozen at zero
                2: program_regs(16'd500, 16'd100, 16'd3000, 16'd50, 16'd0);
                // upper bits of the backoff limit must be masked off
                3: program_regs(16'd65535, 16'd65535, 16'd65535, 16'd1, 16'hfff7);
                5: program_regs(16'd2, 16'd128, 16'd10, 16'd120, 16'd12);
                4, 6: program_regs(CFG_W'($urandom_range(1, 65535)),
                                   CFG_W'($urandom_range(1, 65535)),
                                   CFG_W'($urandom_range(1, 65535)),
                                   CFG_W'($urandom_range(1, 65535)),
                                   CFG_W'($urandom_range(0, 15)));
                default: ;
            endcase

            // Stall the receiver for a long stretch while the sender keeps offering
            if (ph == 1 || ph == 5) hold_req = hold_req + 1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // Pause the sender once until all results are back
                if (ph == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    s_tvalid <= 1'b0;
                    while (pending_timers.size() != 0) @(posedge aclk);
                end
                if ($urandom_range(0, 99) < 20) begin
                    // burst of persist beats; the sample field is junk here
                    run_len = $urandom_range(1, 16);
                    repeat (run_len) begin
                        junk_rtt = 15'($urandom);
                        send_item(FUNC_PERSIST, junk_rtt, 1'b0, '0);
                    end
                    sent = sent + run_len;
                end else begin
                    send_item(FUNC_MEASURE, pick_rtt(), 1'b0, '0);
                    sent = sent + 1;
                end
            end
        end

        // Wait out every expectation, then keep watching for stray beats
        drain_results();
        repeat (8) @(posedge aclk);
        if (timer_mismatches == 0 && pending_timers.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
